FILE: hdl/assert_macros.svh
// Assertion macros shared by the mipmap downsampler modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");
// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, expr)
`endif
`endif

FILE: hdl/mmbd_pkg.sv
// Types, constants and helper functions of the mipmap box downsampler.
`default_nettype none

package mmbd_pkg;

  // Largest supported base size, as a power of two.
  localparam int MAX_SIZE_LOG2 = 8;

  localparam int LOG_W     = 4;
  localparam int GAMMA_W   = 12;
  localparam int CH_W      = 8;
  localparam int TEXEL_W   = 3 * CH_W;
  localparam int PAIR_CH_W = CH_W + 1;
  localparam int PAIR_W    = 3 * PAIR_CH_W;
  localparam int SUM_CH_W  = CH_W + 2;
  localparam int SUM_W     = 3 * SUM_CH_W;
  localparam int PROD_W    = GAMMA_W + SUM_CH_W;
  localparam int COORD_W   = MAX_SIZE_LOG2 - 1;
  localparam int LVL_W     = 4;
  localparam int POS_W     = 2 * MAX_SIZE_LOG2;
  localparam int SUM_LOG_W = $clog2(POS_W + 1);
  localparam int HOLD_IDX_W = $clog2(MAX_SIZE_LOG2);

  // Line buffer of level 1 sits in the front, levels 2 and deeper in the back.
  localparam int LINE_A_DEPTH = 2 ** (MAX_SIZE_LOG2 - 1);
  localparam int LINE_B_DEPTH = 2 ** (MAX_SIZE_LOG2 - 1) - 1;
  localparam int LINE_B_AW    = MAX_SIZE_LOG2 - 1;
  localparam logic [MAX_SIZE_LOG2-1:0] LINE_HALF = MAX_SIZE_LOG2'(1) << (MAX_SIZE_LOG2 - 1);

  // Scaling: (gamma * sum + 2048) >> 12, clamped to one byte.
  localparam int SCALE_SHIFT = 12;
  localparam logic [PROD_W:0] ROUND = (PROD_W + 1)'(2048);
  localparam logic [CH_W-1:0] CH_MAX = 8'hFF;

  // Configuration register map.
  localparam int APB_AW    = 4;
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_WIDTH_LOG2  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_HEIGHT_LOG2 = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_GAMMA_SCALE = 2'd2;
  localparam logic [LOG_W-1:0]   WIDTH_LOG2_RST  = 4'd8;
  localparam logic [LOG_W-1:0]   HEIGHT_LOG2_RST = 4'd8;
  localparam logic [GAMMA_W-1:0] GAMMA_RST       = 12'd1034;

  // What one level does with an incoming texel.
  typedef enum logic [1:0] {
    ACT_STOP,
    ACT_HOLD,
    ACT_STORE,
    ACT_JOIN
  } act_t;

  typedef struct packed {
    logic [LOG_W-1:0]   wl;
    logic [LOG_W-1:0]   hl;
    logic [LOG_W-1:0]   nl;
    logic [GAMMA_W-1:0] gamma;
  } cfg_t;

  // A completed 2x2 block waiting to be scaled: its level, place and sums.
  typedef struct packed {
    logic [LVL_W-1:0]   lv;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [SUM_W-1:0]   sum;
  } job_t;

  typedef struct packed {
    logic [LVL_W-1:0]   level;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [TEXEL_W-1:0] color;
    logic               last;
  } result_t;

  typedef struct packed {
    act_t               act;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [POS_W-1:0]   next_pos;
  } step_t;

  // Position bookkeeping and classification of one level step.
  function automatic step_t lvl_step(input logic [POS_W-1:0] pos,
                                     input logic [LOG_W-1:0] wls,
                                     input logic [LOG_W-1:0] hls,
                                     input logic at_end);
    logic [SUM_LOG_W-1:0] sl;
    logic [POS_W:0] idx;
    logic [POS_W:0] inc;
    logic [POS_W:0] xmask;
    logic [POS_W:0] x;
    logic [POS_W:0] y;
    step_t st;
    sl = SUM_LOG_W'(wls) + SUM_LOG_W'(hls);
    idx = {1'b0, pos};
    // A position past the end of the frame restarts at zero.
    if ((idx >> sl) != '0) begin
      idx = '0;
    end
    inc = idx + 1'b1;
    st.next_pos = ((inc >> sl) != '0) ? '0 : inc[POS_W-1:0];
    xmask = ~({(POS_W + 1){1'b1}} << wls);
    x = idx & xmask;
    y = idx >> wls;
    st.col = x[COORD_W:1];
    st.row = y[COORD_W:1];
    if (at_end) begin
      st.act = ACT_STOP;
    end else if (!x[0]) begin
      st.act = ACT_HOLD;
    end else if (!y[0]) begin
      st.act = ACT_STORE;
    end else begin
      st.act = ACT_JOIN;
    end
    return st;
  endfunction

  // Per-channel sum of two texels.
  function automatic logic [PAIR_W-1:0] pair_sum(input logic [TEXEL_W-1:0] a,
                                                 input logic [TEXEL_W-1:0] b);
    logic [PAIR_CH_W-1:0] r;
    logic [PAIR_CH_W-1:0] g;
    logic [PAIR_CH_W-1:0] bl;
    r  = PAIR_CH_W'(a[3*CH_W-1:2*CH_W]) + PAIR_CH_W'(b[3*CH_W-1:2*CH_W]);
    g  = PAIR_CH_W'(a[2*CH_W-1:CH_W]) + PAIR_CH_W'(b[2*CH_W-1:CH_W]);
    bl = PAIR_CH_W'(a[CH_W-1:0]) + PAIR_CH_W'(b[CH_W-1:0]);
    return {r, g, bl};
  endfunction

  // Per-channel sum of two pair sums: the full 2x2 block.
  function automatic logic [SUM_W-1:0] block_sum(input logic [PAIR_W-1:0] a,
                                                 input logic [PAIR_W-1:0] b);
    logic [SUM_CH_W-1:0] r;
    logic [SUM_CH_W-1:0] g;
    logic [SUM_CH_W-1:0] bl;
    r  = SUM_CH_W'(a[3*PAIR_CH_W-1:2*PAIR_CH_W]) + SUM_CH_W'(b[3*PAIR_CH_W-1:2*PAIR_CH_W]);
    g  = SUM_CH_W'(a[2*PAIR_CH_W-1:PAIR_CH_W]) + SUM_CH_W'(b[2*PAIR_CH_W-1:PAIR_CH_W]);
    bl = SUM_CH_W'(a[PAIR_CH_W-1:0]) + SUM_CH_W'(b[PAIR_CH_W-1:0]);
    return {r, g, bl};
  endfunction

endpackage

`default_nettype wire

FILE: hdl/mipmap_box_downsampler.sv
// Top level of the streaming 2x2 box-filter mipmap generator.
// Base texels enter on the texel channel (in_valid/in_ready) in raster order, one item
// per cycle while in_ready is high. Every texel that completes a 2x2 block gives a
// result item on the output channel (out_valid/out_ready) with level, col, row and
// color; one texel can complete blocks at several levels, and last_of_run marks the
// final result of that texel. A level 1 result passes the front end stage, the queue,
// stage B and the output register; deeper levels of the run follow through the back
// end line buffer read loop. Throughput: one texel per cycle while in_ready is high;
// the back end takes one level 1 block per cycle while the output moves, and a block
// that chains deeper holds it until its levels are done. An 8-entry queue (QUEUE_DEPTH)
// absorbs these bursts; in_ready drops only when it is full and the front end holds a
// finished block. When the receiver stalls, the result waits in the output register,
// the back end stops and the queue fills, then input stalls too; no item is lost.
// Reset (synchronous) restores width_log2 = height_log2 = 8 and gamma_scale = 1034,
// and clears all positions and held texels. The line buffers are not cleared: they
// are always written before they are read within a frame.
// Registers sit on the APB port at byte addresses 0, 4 and 8; write only when idle.
`default_nettype none

module mipmap_box_downsampler #(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  // Configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mmbd_pkg::APB_AW-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  // Texel input
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [mmbd_pkg::TEXEL_W-1:0]  texel,
  // Result output
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mmbd_pkg::LVL_W-1:0]    level,
  output logic [mmbd_pkg::COORD_W-1:0]  col,
  output logic [mmbd_pkg::COORD_W-1:0]  row,
  output logic [mmbd_pkg::TEXEL_W-1:0]  color,
  output logic                          last_of_run
);
  import mmbd_pkg::*;

  logic [LOG_W-1:0]     width_log2;
  logic [LOG_W-1:0]     height_log2;
  logic [GAMMA_W-1:0]   gamma_scale;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 reg_write;
  logic [LOG_W-1:0]     wl_sat;
  logic [LOG_W-1:0]     hl_sat;
  cfg_t                 cfg;
  logic                 q_push;
  logic                 q_full;
  logic                 q_pop;
  logic                 q_valid;
  job_t                 q_in;
  job_t                 q_out;
  result_t              res;

  // Register access.
  always_comb begin
    pready    = 1'b1;
    reg_idx   = paddr[APB_AW-1:2];
    reg_write = psel && penable && pwrite;
    prdata    = '0;
    unique case (reg_idx)
      REG_WIDTH_LOG2:  prdata = 32'(width_log2);
      REG_HEIGHT_LOG2: prdata = 32'(height_log2);
      REG_GAMMA_SCALE: prdata = 32'(gamma_scale);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_log2  <= WIDTH_LOG2_RST;
      height_log2 <= HEIGHT_LOG2_RST;
      gamma_scale <= GAMMA_RST;
    end else if (reg_write) begin
      unique case (reg_idx)
        REG_WIDTH_LOG2:  width_log2  <= pwdata[LOG_W-1:0];
        REG_HEIGHT_LOG2: height_log2 <= pwdata[LOG_W-1:0];
        REG_GAMMA_SCALE: gamma_scale <= pwdata[GAMMA_W-1:0];
        default:         ;
      endcase
    end
  end

  // Sizes saturate at the largest supported texture; the chain ends at the smaller side.
  always_comb begin
    wl_sat    = (width_log2 > LOG_W'(MAX_SIZE_LOG2)) ? LOG_W'(MAX_SIZE_LOG2) : width_log2;
    hl_sat    = (height_log2 > LOG_W'(MAX_SIZE_LOG2)) ? LOG_W'(MAX_SIZE_LOG2) : height_log2;
    cfg.wl    = wl_sat;
    cfg.hl    = hl_sat;
    cfg.nl    = (wl_sat < hl_sat) ? wl_sat : hl_sat;
    cfg.gamma = gamma_scale;
  end

  mmbd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .texel    (texel),
    .q_push   (q_push),
    .q_job    (q_in),
    .q_full   (q_full)
  );

  mmbd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_in),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_out),
    .valid (q_valid)
  );

  mmbd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_job     (q_out),
    .q_pop     (q_pop),
    .res_valid (out_valid),
    .res_ready (out_ready),
    .res       (res)
  );

  // Result fields.
  always_comb begin
    level       = res.level;
    col         = res.col;
    row         = res.row;
    color       = res.color;
    last_of_run = res.last;
  end

endmodule

`default_nettype wire

FILE: hdl/mmbd_front.sv
// Front end: takes base texels, tracks level 0 and completes level 1 blocks.
`default_nettype none

module mmbd_front (
  input  logic                        clk,
  input  logic                        rst,
  input  mmbd_pkg::cfg_t              cfg,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [mmbd_pkg::TEXEL_W-1:0] texel,
  output logic                        q_push,
  output mmbd_pkg::job_t              q_job,
  input  logic                        q_full
);
  import mmbd_pkg::*;

  logic [POS_W-1:0]   pos0;
  logic [TEXEL_W-1:0] hold0;
  logic [PAIR_W-1:0]  line_mem [LINE_A_DEPTH];
  logic [PAIR_W-1:0]  line_rdata;
  logic               accept;
  step_t              step0;
  logic [PAIR_W-1:0]  pair0;
  logic               f2_valid;
  logic [PAIR_W-1:0]  f2_pair;
  logic [COORD_W-1:0] f2_col;
  logic [COORD_W-1:0] f2_row;

  // Classify the incoming texel against the level 0 position.
  always_comb begin
    in_ready = !(f2_valid && q_full);
    accept   = in_valid && in_ready;
    step0    = lvl_step(pos0, cfg.wl, cfg.hl, cfg.nl == '0);
    pair0    = pair_sum(hold0, texel);
  end

  // A joined block leaves the second stage as a level 1 item.
  always_comb begin
    q_push    = f2_valid && !q_full;
    q_job.lv  = LVL_W'(1);
    q_job.col = f2_col;
    q_job.row = f2_row;
    q_job.sum = block_sum(line_rdata, f2_pair);
  end

  // Level 0 state and the second stage valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos0     <= '0;
      hold0    <= '0;
      f2_valid <= 1'b0;
    end else begin
      if (accept) begin
        pos0     <= step0.next_pos;
        f2_valid <= (step0.act == ACT_JOIN);
        if (step0.act == ACT_HOLD) begin
          hold0 <= texel;
        end
      end else if (q_push) begin
        f2_valid <= 1'b0;
      end
    end
  end

  // Second stage payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      f2_pair <= pair0;
      f2_col  <= step0.col;
      f2_row  <= step0.row;
    end
  end

  // Level 1 line of pair sums from even rows.
  always_ff @(posedge clk) begin
    if (accept && step0.act == ACT_STORE) begin
      line_mem[step0.col] <= pair0;
    end
    if (accept && step0.act == ACT_JOIN) begin
      line_rdata <= line_mem[step0.col];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/mmbd_queue.sv
// Small FIFO of completed level 1 blocks between front and back.
`default_nettype none

module mmbd_queue #(
  parameter int DEPTH = 8
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  mmbd_pkg::job_t din,
  output logic           full,
  input  logic           pop,
  output mmbd_pkg::job_t dout,
  output logic           valid
);
  import mmbd_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  always_comb begin
    full  = (count == CNT_W'(DEPTH));
    valid = (count != '0);
    dout  = slots[rd_ptr];
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

`include "assert_macros.svh"

  `ASSERT_NEVER(a_push_full, clk, rst, push && full)
  `ASSERT_NEVER(a_pop_empty, clk, rst, pop && !valid)
  `ASSERT_ALWAYS(a_count_range, clk, rst, count <= CNT_W'(DEPTH))

endmodule

`default_nettype wire

FILE: hdl/mmbd_back.sv
// Back end: scales blocks into results and runs the cascade of deeper levels.
`default_nettype none

module mmbd_back (
  input  logic              clk,
  input  logic              rst,
  input  mmbd_pkg::cfg_t    cfg,
  input  logic              q_valid,
  input  mmbd_pkg::job_t    q_job,
  output logic              q_pop,
  output logic              res_valid,
  input  logic              res_ready,
  output mmbd_pkg::result_t res
);
  import mmbd_pkg::*;

  // Level state for levels 1 and deeper.
  logic [POS_W-1:0]   pos [1:MAX_SIZE_LOG2];
  logic [TEXEL_W-1:0] hold [1:MAX_SIZE_LOG2-1];
  logic [PAIR_W-1:0]  line_mem [LINE_B_DEPTH];
  logic [PAIR_W-1:0]  line_rdata;

  // Stage A: select, classify, multiply.
  logic               advance;
  logic               a_from_q;
  logic               a_valid;
  job_t               a_job;
  job_t               cont_job;
  step_t              a_step;
  logic [LOG_W-1:0]   a_wls;
  logic [LOG_W-1:0]   a_hls;
  logic [PROD_W-1:0]  a_prod_r;
  logic [PROD_W-1:0]  a_prod_g;
  logic [PROD_W-1:0]  a_prod_b;

  // Stage B: round, clamp, update level state.
  logic               b_valid;
  act_t               b_act;
  logic [LVL_W-1:0]   b_lv;
  logic [COORD_W-1:0] b_col;
  logic [COORD_W-1:0] b_row;
  logic [COORD_W-1:0] b_ncol;
  logic [COORD_W-1:0] b_nrow;
  logic [PROD_W-1:0]  b_prod_r;
  logic [PROD_W-1:0]  b_prod_g;
  logic [PROD_W-1:0]  b_prod_b;
  logic [TEXEL_W-1:0] b_color;
  logic [TEXEL_W-1:0] b_hold;
  logic [PAIR_W-1:0]  b_pair;
  logic [MAX_SIZE_LOG2-1:0] b_base;
  logic [LINE_B_AW-1:0] b_addr;

  // Stage C: line read returns, block goes back to stage A.
  logic               c_valid;
  logic [LVL_W-1:0]   c_lv;
  logic [COORD_W-1:0] c_col;
  logic [COORD_W-1:0] c_row;
  logic [PAIR_W-1:0]  c_pair;

  function automatic logic [CH_W-1:0] scale_ch(input logic [PROD_W-1:0] p);
    logic [PROD_W:0] t;
    logic [PROD_W-SCALE_SHIFT:0] hi;
    t  = {1'b0, p} + ROUND;
    hi = t[PROD_W:SCALE_SHIFT];
    return (hi > (PROD_W - SCALE_SHIFT + 1)'(CH_MAX)) ? CH_MAX : hi[CH_W-1:0];
  endfunction

  // Continuation has priority; a new level 1 block waits while a join is in flight.
  always_comb begin
    advance      = !b_valid || !res_valid || res_ready;
    cont_job.lv  = c_lv;
    cont_job.col = c_col;
    cont_job.row = c_row;
    cont_job.sum = block_sum(line_rdata, c_pair);
    a_from_q     = !c_valid && !(b_valid && b_act == ACT_JOIN) && q_valid;
    a_valid      = c_valid || a_from_q;
    a_job        = c_valid ? cont_job : q_job;
    q_pop        = a_from_q && advance;
    a_wls        = cfg.wl - a_job.lv;
    a_hls        = cfg.hl - a_job.lv;
    a_step       = lvl_step(pos[a_job.lv], a_wls, a_hls, a_job.lv >= cfg.nl);
    a_prod_r     = PROD_W'(cfg.gamma) * PROD_W'(a_job.sum[3*SUM_CH_W-1:2*SUM_CH_W]);
    a_prod_g     = PROD_W'(cfg.gamma) * PROD_W'(a_job.sum[2*SUM_CH_W-1:SUM_CH_W]);
    a_prod_b     = PROD_W'(cfg.gamma) * PROD_W'(a_job.sum[SUM_CH_W-1:0]);
  end

  // Scaled color, pair with the held texel and the line address of the next level.
  always_comb begin
    b_color = {scale_ch(b_prod_r), scale_ch(b_prod_g), scale_ch(b_prod_b)};
    b_hold  = hold[b_lv[HOLD_IDX_W-1:0]];
    b_pair  = pair_sum(b_hold, b_color);
    b_base  = LINE_HALF - (MAX_SIZE_LOG2'(1) << (LVL_W'(MAX_SIZE_LOG2) - b_lv));
    b_addr  = b_base[LINE_B_AW-1:0] + b_ncol;
  end

  // Valid flags, level positions and held texels.
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid   <= 1'b0;
      c_valid   <= 1'b0;
      res_valid <= 1'b0;
      for (int i = 1; i <= MAX_SIZE_LOG2; i++) begin
        pos[i] <= '0;
      end
      for (int i = 1; i < MAX_SIZE_LOG2; i++) begin
        hold[i] <= '0;
      end
    end else begin
      if (advance) begin
        b_valid <= a_valid;
        c_valid <= b_valid && (b_act == ACT_JOIN);
        if (a_valid) begin
          pos[a_job.lv] <= a_step.next_pos;
        end
        if (b_valid && b_act == ACT_HOLD) begin
          hold[b_lv[HOLD_IDX_W-1:0]] <= b_color;
        end
      end
      res_valid <= (advance && b_valid) || (res_valid && !res_ready);
    end
  end

  // Stage payloads and the output register.
  always_ff @(posedge clk) begin
    if (advance) begin
      b_act    <= a_step.act;
      b_lv     <= a_job.lv;
      b_col    <= a_job.col;
      b_row    <= a_job.row;
      b_ncol   <= a_step.col;
      b_nrow   <= a_step.row;
      b_prod_r <= a_prod_r;
      b_prod_g <= a_prod_g;
      b_prod_b <= a_prod_b;
      c_lv     <= b_lv + 1'b1;
      c_col    <= b_ncol;
      c_row    <= b_nrow;
      c_pair   <= b_pair;
      if (b_valid) begin
        res.level <= b_lv;
        res.col   <= b_col;
        res.row   <= b_row;
        res.color <= b_color;
        res.last  <= (b_act != ACT_JOIN);
      end
    end
  end

  // Line of pair sums for levels 2 and deeper.
  always_ff @(posedge clk) begin
    if (advance && b_valid && b_act == ACT_STORE) begin
      line_mem[b_addr] <= b_pair;
    end
    if (advance && b_valid && b_act == ACT_JOIN) begin
      line_rdata <= line_mem[b_addr];
    end
  end

`include "assert_macros.svh"

  `ASSERT_ALWAYS(a_cont_alone, clk, rst, c_valid |-> !b_valid)
  `ASSERT_NEVER(a_pop_during_cont, clk, rst, q_pop && c_valid)
  `ASSERT_ALWAYS(a_join_depth, clk, rst, (b_valid && b_act == ACT_JOIN) |-> (b_lv < cfg.nl))

endmodule

`default_nettype wire
